// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The antecedent implies the consequent at the same clock edge.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/tetp_pkg.sv =====
// ----------------------------------------------------------------------------
// Trend end time predictor package
// Constants used by the predictor module.
// ----------------------------------------------------------------------------
package tetp_pkg;

    localparam int WINDOW_DEFAULT = 10;
    localparam int QUOT_CAP_BITS = 20;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GOAL_WEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_OFFSET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TREND_WEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DURATION_MS = 2'd3;

    localparam logic [15:0] GOAL_WEIGHT_RESET = 16'd3600;
    localparam logic [8:0] WEIGHT_OFFSET_RESET = 9'd0;
    localparam logic [15:0] MIN_TREND_WEIGHT_RESET = 16'd1000;
    localparam logic [15:0] MAX_DURATION_MS_RESET = 16'd50000;

    localparam logic OP_CLEAR = 1'b0;

endpackage

// ===== src/tetp_if.sv =====
// ----------------------------------------------------------------------------
// Trend end time predictor channels
// Valid/ready channels for samples and for predictions.
// ----------------------------------------------------------------------------
interface tetp_in_if;
    logic valid;
    logic ready;
    logic op;
    logic [15:0] sample_time_ms;
    logic signed [15:0] sample_weight_cg;

    modport source(output valid, op, sample_time_ms, sample_weight_cg, input ready);
    modport sink(input valid, op, sample_time_ms, sample_weight_cg, output ready);
endinterface

interface tetp_out_if;
    logic valid;
    logic ready;
    logic [15:0] expected_end_ms;
    logic from_trend;

    modport source(output valid, expected_end_ms, from_trend, input ready);
    modport sink(input valid, expected_end_ms, from_trend, output ready);
endinterface

// ===== src/trend_end_time_predictor.sv =====
// ----------------------------------------------------------------------------
// Trend end time predictor
// Fits a least-squares line over the last WINDOW weight samples and
// predicts when the weight reaches the goal minus the offset.
// ----------------------------------------------------------------------------
// Samples arrive on sample_in, one transfer per item; op low clears the
// window, op high adds a sample. Every transfer gives exactly one result on
// result_out. The user must write registers through cfg_write, cfg_index
// and cfg_data only while the block is idle; the block does not enforce it.
// A clear, a sample that leaves the window not yet full, or a sample whose
// weight is below the minimum goes straight to S_FIN with the default. A
// full window steps through S_ACC_MUL and S_ACC_ADD once per sample for the
// sums, then S_NUM and S_DEN for the products; a slope or denominator that
// is not positive gives the default from S_CHK. Otherwise the serial
// multiplier (one bit of the weight term a cycle) runs beside the first of
// two runs of the serial divider, one quotient bit a cycle over the full
// product width. One item is in work at a time; sample_in is ready again as
// soon as the result is in the output register.
// Reset empties the window and loads the register defaults. When the
// receiver stalls, the result waits in the output register and a finished
// next result waits until that slot is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trend_end_time_predictor #(
    parameter int WINDOW = tetp_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tetp_in_if.sink                          sample_in,
    tetp_out_if.source                       result_out,
    input  logic                             cfg_write,
    input  logic [tetp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tetp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int WB = $clog2(WINDOW + 1);
    localparam int IW = $clog2(WINDOW);
    localparam int TW = 16 + WB;
    localparam int SW = 16 + WB;
    localparam int TTW = 32 + WB;
    localparam int TWW = 32 + WB;
    localparam int NW = 2 * WB + 34;
    localparam int AW = 18 + WB;
    localparam int MW = AW + NW;
    localparam int DVW = WB + NW;
    localparam int MCW = $clog2(AW + 1);
    localparam int QW = tetp_pkg::QUOT_CAP_BITS + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACC_MUL = 4'd1;
    localparam logic [3:0] S_ACC_ADD = 4'd2;
    localparam logic [3:0] S_NUM = 4'd3;
    localparam logic [3:0] S_DEN = 4'd4;
    localparam logic [3:0] S_CHK = 4'd5;
    localparam logic [3:0] S_MUL = 4'd6;
    localparam logic [3:0] S_DIV1 = 4'd7;
    localparam logic [3:0] S_DIV2 = 4'd8;
    localparam logic [3:0] S_FIN = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [15:0] goal_reg;
    logic [8:0]  offset_reg;
    logic [15:0] min_reg;
    logic [15:0] maxdur_reg;

    logic [15:0]        time_mem_reg [WINDOW];
    logic signed [15:0] wt_mem_reg [WINDOW];

    logic [WB-1:0] count_reg, count_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [MCW-1:0] mul_cnt_reg, mul_cnt_next;

    logic [TW-1:0]         st_reg, st_next;
    logic signed [SW-1:0]  sw_reg, sw_next;
    logic [TTW-1:0]        stt_reg, stt_next;
    logic signed [TWW-1:0] stw_reg, stw_next;
    logic [31:0]           tt_reg, tt_next;
    logic signed [32:0]    tw_reg, tw_next;
    logic signed [NW-1:0]  p_reg, p_next;
    logic [2*TW-1:0]       p2_reg, p2_next;
    logic signed [NW-1:0]  num_reg, num_next;
    logic signed [NW-1:0]  den_calc;
    logic signed [AW-1:0]  a_calc;
    logic signed [AW-1:0]  tgt_calc;
    logic                  neg_reg, neg_next;
    logic [MW-1:0]         mul_a_reg, mul_a_next;
    logic [AW-1:0]         mul_b_reg, mul_b_next;
    logic [MW-1:0]         mul_acc_reg, mul_acc_next;
    logic [15:0]           stq_reg, stq_next;

    logic [15:0] res_end_reg, res_end_next;
    logic        res_trend_reg, res_trend_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_end_reg, out_end_next;
    logic        out_trend_reg, out_trend_next;

    logic           in_fire;
    logic           div_start;
    logic [MW-1:0]  div_dividend;
    logic [DVW-1:0] div_divisor;
    logic           div_done;
    logic [MW-1:0]  div_quot;
    logic [QW-1:0]  qcap;
    logic signed [QW+2:0] end_calc;
    logic [15:0]    t_rd;
    logic signed [15:0] w_rd;

    tetp_div #(
        .DDW(MW),
        .DSW(DVW)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_dividend),
        .divisor(div_divisor),
        .done(div_done),
        .quotient(div_quot)
    );

    assign sample_in.ready = (state_reg == S_IDLE);
    assign in_fire = sample_in.valid && sample_in.ready;
    assign result_out.valid = out_valid_reg;
    assign result_out.expected_end_ms = out_end_reg;
    assign result_out.from_trend = out_trend_reg;

    always_comb
    begin
        t_rd = time_mem_reg[idx_reg];
        w_rd = wt_mem_reg[idx_reg];
        den_calc = $signed(NW'(WINDOW)) * $signed(NW'(stt_reg)) - $signed(NW'(p2_reg));
        tgt_calc = $signed(AW'({1'b0, goal_reg})) - $signed(AW'({1'b0, offset_reg}));
        a_calc = $signed(AW'(WINDOW)) * tgt_calc - AW'(sw_reg);
        qcap = (div_quot > MW'(1 << tetp_pkg::QUOT_CAP_BITS))
            ? QW'(1 << tetp_pkg::QUOT_CAP_BITS) : div_quot[QW-1:0];
        end_calc = neg_reg
            ? $signed({3'b000, stq_reg}) - $signed({3'b000, qcap})
            : $signed({3'b000, stq_reg}) + $signed({3'b000, qcap});

        state_next = state_reg;
        count_next = count_reg;
        slot_next = slot_reg;
        idx_next = idx_reg;
        mul_cnt_next = mul_cnt_reg;
        st_next = st_reg;
        sw_next = sw_reg;
        stt_next = stt_reg;
        stw_next = stw_reg;
        tt_next = tt_reg;
        tw_next = tw_reg;
        p_next = p_reg;
        p2_next = p2_reg;
        num_next = num_reg;
        neg_next = neg_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        mul_acc_next = mul_acc_reg;
        stq_next = stq_reg;
        res_end_next = res_end_reg;
        res_trend_next = res_trend_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_end_next = out_end_reg;
        out_trend_next = out_trend_reg;
        div_start = 1'b0;
        div_dividend = MW'(st_reg);
        div_divisor = DVW'(WINDOW);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_end_next = maxdur_reg;
                    res_trend_next = 1'b0;
                    state_next = S_FIN;
                    if (sample_in.op == tetp_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = (slot_reg == IW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                        if (count_reg != WB'(WINDOW))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if ((count_next == WB'(WINDOW)) &&
                            !($signed({sample_in.sample_weight_cg[15],
                                       sample_in.sample_weight_cg})
                              < $signed({1'b0, min_reg})))
                        begin
                            state_next = S_ACC_MUL;
                            idx_next = '0;
                            st_next = '0;
                            sw_next = '0;
                            stt_next = '0;
                            stw_next = '0;
                        end
                    end
                end
            end
            S_ACC_MUL:
            begin
                tt_next = t_rd * t_rd;
                tw_next = $signed({1'b0, t_rd}) * w_rd;
                st_next = st_reg + TW'(t_rd);
                sw_next = sw_reg + SW'(w_rd);
                state_next = S_ACC_ADD;
            end
            S_ACC_ADD:
            begin
                stt_next = stt_reg + TTW'(tt_reg);
                stw_next = stw_reg + TWW'(tw_reg);
                idx_next = idx_reg + 1'b1;
                state_next = (idx_reg == IW'(WINDOW - 1)) ? S_NUM : S_ACC_MUL;
            end
            S_NUM:
            begin
                p_next = $signed({1'b0, st_reg}) * sw_reg;
                p2_next = st_reg * st_reg;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                num_next = $signed(NW'(WINDOW)) * NW'(stw_reg) - p_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((num_reg <= 0) || (den_calc <= 0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    neg_next = a_calc[AW-1];
                    mul_a_next = MW'(unsigned'(den_calc));
                    mul_b_next = a_calc[AW-1] ? AW'(-a_calc) : AW'(a_calc);
                    mul_acc_next = '0;
                    mul_cnt_next = MCW'(AW);
                    div_start = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_cnt_reg == '0)
                begin
                    state_next = S_DIV1;
                end
                else
                begin
                    if (mul_b_reg[0])
                    begin
                        mul_acc_next = mul_acc_reg + mul_a_reg;
                    end
                    mul_a_next = {mul_a_reg[MW-2:0], 1'b0};
                    mul_b_next = {1'b0, mul_b_reg[AW-1:1]};
                    mul_cnt_next = mul_cnt_reg - 1'b1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    stq_next = div_quot[15:0];
                    div_start = 1'b1;
                    div_dividend = mul_acc_reg;
                    div_divisor = DVW'(WINDOW) * DVW'(unsigned'(num_reg));
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    res_trend_next = 1'b1;
                    if (end_calc < 0)
                    begin
                        res_end_next = '0;
                    end
                    else if (end_calc > $signed((QW+3)'(16'hFFFF)))
                    begin
                        res_end_next = 16'hFFFF;
                    end
                    else
                    begin
                        res_end_next = end_calc[15:0];
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_end_next = res_end_reg;
                    out_trend_next = res_trend_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            slot_reg <= '0;
            idx_reg <= '0;
            mul_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            goal_reg <= tetp_pkg::GOAL_WEIGHT_RESET;
            offset_reg <= tetp_pkg::WEIGHT_OFFSET_RESET;
            min_reg <= tetp_pkg::MIN_TREND_WEIGHT_RESET;
            maxdur_reg <= tetp_pkg::MAX_DURATION_MS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            slot_reg <= slot_next;
            idx_reg <= idx_next;
            mul_cnt_reg <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    tetp_pkg::CFG_GOAL_WEIGHT:      goal_reg <= cfg_data;
                    tetp_pkg::CFG_WEIGHT_OFFSET:    offset_reg <= cfg_data[8:0];
                    tetp_pkg::CFG_MIN_TREND_WEIGHT: min_reg <= cfg_data;
                    tetp_pkg::CFG_MAX_DURATION_MS:  maxdur_reg <= cfg_data;
                    default:                        goal_reg <= goal_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (sample_in.op != tetp_pkg::OP_CLEAR))
        begin
            time_mem_reg[slot_reg] <= sample_in.sample_time_ms;
            wt_mem_reg[slot_reg] <= sample_in.sample_weight_cg;
        end
        st_reg <= st_next;
        sw_reg <= sw_next;
        stt_reg <= stt_next;
        stw_reg <= stw_next;
        tt_reg <= tt_next;
        tw_reg <= tw_next;
        p_reg <= p_next;
        p2_reg <= p2_next;
        num_reg <= num_next;
        neg_reg <= neg_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        mul_acc_reg <= mul_acc_next;
        stq_reg <= stq_next;
        res_end_reg <= res_end_next;
        res_trend_reg <= res_trend_next;
        out_end_reg <= out_end_next;
        out_trend_reg <= out_trend_next;
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= WB'(WINDOW))
    `ASSERT_ALWAYS(a_slot_bound, slot_reg <= IW'(WINDOW - 1))
    `ASSERT_IMPLIES(a_div_done_state, div_done, (state_reg == S_DIV1) || (state_reg == S_DIV2))
    `ASSERT_IMPLIES(a_fit_needs_full, state_reg == S_ACC_MUL, count_reg == WB'(WINDOW))

endmodule

// ===== src/tetp_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tetp_div #(
    parameter int DDW = 64,
    parameter int DSW = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DDW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DDW-1:0] quotient
);

    localparam int CW = $clog2(DDW + 1);

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [DDW-1:0] q_reg, q_next;
    logic [DSW-1:0] r_reg, r_next;
    logic [DSW-1:0] d_reg, d_next;
    logic [DSW:0]   r_shift;
    logic           ge;

    always_comb
    begin
        r_shift = {r_reg, q_reg[DDW-1]};
        ge = (r_shift >= {1'b0, d_reg});
        cnt_next = cnt_reg;
        done_next = 1'b0;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        if (start)
        begin
            cnt_next = CW'(DDW);
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            q_next = {q_reg[DDW-2:0], ge};
            r_next = ge ? DSW'(r_shift - {1'b0, d_reg}) : r_shift[DSW-1:0];
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;

endmodule
